// File: rtl/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
package gha_pkg;

  localparam int unsigned SLOT_BITS   = 20;
  localparam int unsigned GEN_BITS    = 12;
  localparam int unsigned HANDLE_BITS = SLOT_BITS + GEN_BITS;

  localparam logic [GEN_BITS-1:0] GEN_MAX = 12'hFFF;
  localparam logic [GEN_BITS-1:0] GEN_ONE = 12'h001;

  typedef enum logic [1:0] {
    KIND_ALLOCATE = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_VALIDATE = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_RSVD    = 2'd3
  } status_t;

  // One entry of the slot table.
  typedef struct packed {
    logic                in_use;
    logic [GEN_BITS-1:0] gen;
  } slot_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_POP  = 4'b0010,
    ST_READ = 4'b0100,
    ST_EXEC = 4'b1000
  } state_t;

endpackage

// File: rtl/gha_slot_mem.sv
// Slot table memory: in-use bit and generation per slot, with a registered read.
module gha_slot_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  gha_pkg::slot_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output gha_pkg::slot_entry_t rd_data
);

  gha_pkg::slot_entry_t mem [DEPTH];
  gha_pkg::slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/gha_free_stack.sv
// Free stack memory holding released slot numbers, with a registered read.
module gha_free_stack #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/generational_handle_allocator.sv
// Top level of the generational handle allocator: sequencer, counters and result register.
//
// Handles are {generation[11:0], slot[19:0]}; generations run 1..4095 and wrap to 1, so
// handle 0 is never issued. Each transaction runs alone through the slot table and free
// stack. Both are memories with separate read and write ports and a registered read.
// An allocate that reuses a freed slot passes through the pop, read and execute states
// (stack read, then slot table read, then update) before it loads the result register.
// Every other transaction passes through the read and execute states only. The input
// stalls until that update, so no new transaction is accepted before the last one is done.
// A new transaction is accepted while a finished result waits in the output register, and the
// update step waits only when that register is still full. Slots beyond the fresh-slot count
// are treated as never written, so no clearing pass runs after reset and the block is ready
// at once.
module generational_handle_allocator #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_handle_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_handle_out,
  output logic [1:0]  out_status
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned CMPW = gha_pkg::SLOT_BITS + 1;

  gha_pkg::state_t state_r, state_nxt;

  logic [1:0]                     kind_r;
  logic [gha_pkg::HANDLE_BITS-1:0] handle_r;
  logic                           pop_r;
  logic [SW-1:0]                  slot_r;
  logic [CW-1:0]                  free_r, free_nxt;
  logic [CW-1:0]                  fresh_r, fresh_nxt;

  logic                           out_valid_r;
  logic [gha_pkg::HANDLE_BITS-1:0] out_handle_r;
  logic [1:0]                     out_status_r;

  logic                 accept;
  logic                 exec_fire;
  logic [CW-1:0]        pop_idx;
  logic [SW-1:0]        slot_addr;

  gha_pkg::slot_entry_t slot_rd, slot_wr;
  logic                 slot_we;
  logic [SW-1:0]        stack_rd;
  logic                 stack_we;

  logic [gha_pkg::SLOT_BITS-1:0] h_slot;
  logic [gha_pkg::GEN_BITS-1:0]  h_gen;
  logic                          h_ok;
  logic [gha_pkg::GEN_BITS-1:0]  old_gen, new_gen;
  logic                          fresh_avail;

  logic [gha_pkg::HANDLE_BITS-1:0] res_handle;
  logic [1:0]                      res_status;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != gha_pkg::ST_IDLE);
  assign exec_fire = (state_r == gha_pkg::ST_EXEC) && (!out_valid_r || !out_stall);
  assign pop_idx   = free_r - 1'b1;

  // Slot chosen for the table read: popped slot, next fresh slot, or the handle's slot.
  always_comb begin
    if (pop_r) begin
      slot_addr = stack_rd;
    end else if (kind_r == gha_pkg::KIND_ALLOCATE) begin
      slot_addr = fresh_r[SW-1:0];
    end else begin
      slot_addr = handle_r[SW-1:0];
    end
  end

  assign h_slot      = handle_r[gha_pkg::SLOT_BITS-1:0];
  assign h_gen       = handle_r[gha_pkg::HANDLE_BITS-1:gha_pkg::SLOT_BITS];
  assign h_ok        = (handle_r != '0) && (CMPW'(h_slot) < CMPW'(fresh_r)) &&
                       slot_rd.in_use && (h_gen == slot_rd.gen);
  assign fresh_avail = (fresh_r < CW'(SLOTS));
  // A fresh slot has never been written, so its generation starts from zero.
  assign old_gen     = pop_r ? slot_rd.gen : '0;
  assign new_gen     = (old_gen >= gha_pkg::GEN_MAX) ? gha_pkg::GEN_ONE : old_gen + 1'b1;

  always_comb begin
    free_nxt   = free_r;
    fresh_nxt  = fresh_r;
    slot_we    = 1'b0;
    slot_wr    = slot_rd;
    stack_we   = 1'b0;
    res_handle = '0;
    res_status = gha_pkg::STATUS_INVALID;
    unique case (kind_r)
      gha_pkg::KIND_ALLOCATE: begin
        if (pop_r || fresh_avail) begin
          slot_we        = exec_fire;
          slot_wr.in_use = 1'b1;
          slot_wr.gen    = new_gen;
          res_handle     = {new_gen, gha_pkg::SLOT_BITS'(slot_r)};
          res_status     = gha_pkg::STATUS_OK;
          if (pop_r) begin
            free_nxt = pop_idx;
          end else begin
            fresh_nxt = fresh_r + 1'b1;
          end
        end else begin
          res_status = gha_pkg::STATUS_FULL;
        end
      end
      gha_pkg::KIND_RELEASE: begin
        if (h_ok) begin
          slot_we        = exec_fire;
          slot_wr.in_use = 1'b0;
          res_status     = gha_pkg::STATUS_OK;
          if (free_r < CW'(SLOTS)) begin
            stack_we = exec_fire;
            free_nxt = free_r + 1'b1;
          end
        end
      end
      gha_pkg::KIND_VALIDATE: begin
        if (h_ok) begin
          res_status = gha_pkg::STATUS_OK;
        end
      end
      default: begin
        res_status = gha_pkg::STATUS_INVALID;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gha_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_kind == gha_pkg::KIND_ALLOCATE) && (free_r != '0)) begin
            state_nxt = gha_pkg::ST_POP;
          end else begin
            state_nxt = gha_pkg::ST_READ;
          end
        end
      end
      gha_pkg::ST_POP:  state_nxt = gha_pkg::ST_READ;
      gha_pkg::ST_READ: state_nxt = gha_pkg::ST_EXEC;
      gha_pkg::ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = gha_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gha_pkg::ST_IDLE;
      free_r      <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
      pop_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        pop_r <= (in_kind == gha_pkg::KIND_ALLOCATE) && (free_r != '0);
      end
      if (exec_fire) begin
        free_r      <= free_nxt;
        fresh_r     <= fresh_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      handle_r <= in_handle_in;
    end
    if (state_r == gha_pkg::ST_READ) begin
      slot_r <= slot_addr;
    end
    if (exec_fire) begin
      out_handle_r <= res_handle;
      out_status_r <= res_status;
    end
  end

  gha_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (SW)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_r),
    .wr_data (slot_wr),
    .rd_en   (state_r == gha_pkg::ST_READ),
    .rd_addr (slot_addr),
    .rd_data (slot_rd)
  );

  gha_free_stack #(
    .DEPTH (SLOTS),
    .AW    (SW)
  ) u_free_stack (
    .clk     (clk),
    .wr_en   (stack_we),
    .wr_addr (free_r[SW-1:0]),
    .wr_data (slot_r),
    .rd_en   (state_r == gha_pkg::ST_POP),
    .rd_addr (pop_idx[SW-1:0]),
    .rd_data (stack_rd)
  );

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_status     = out_status_r;

endmodule

// File: tb/tb_generational_handle_allocator.sv
// Self-checking testbench for the generational handle allocator.
module tb_generational_handle_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 1024;

  typedef struct {
    gha_pkg::kind_t kind;
    logic [31:0]    handle;
  } request_t;

  typedef struct {
    logic [31:0]      handle;
    gha_pkg::status_t status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = gha_pkg::KIND_ALLOCATE;
  logic [31:0] in_handle_in = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_handle_out;
  logic [1:0]  out_status;

  generational_handle_allocator #(
    .SLOTS(SLOTS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_handle_in  (in_handle_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_handle_out(out_handle_out),
    .out_status    (out_status)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow copy of the allocator state, advanced once per accepted transaction.
  logic                         slot_busy [SLOTS];
  logic [gha_pkg::GEN_BITS-1:0] slot_gen [SLOTS];
  logic [9:0]                   free_slots [SLOTS];
  int unsigned                  free_depth = 0;
  int unsigned                  fresh_taken = 0;
  int unsigned                  full_answers = 0;
  logic [31:0]                  live_handles [$];
  logic [31:0]                  retired_handles [$];

  request_t    pending_requests [$];
  result_t     awaited_results [$];
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  bit          calm = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_gen[i] = '0;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic bit handle_live(input logic [31:0] h);
    if (h == 32'h0) return 1'b0;
    if (h[19:0] >= SLOTS || h[19:0] >= fresh_taken) return 1'b0;
    return slot_busy[h[9:0]] && (h[31:20] == slot_gen[h[9:0]]);
  endfunction

  function automatic void predict_transaction(input gha_pkg::kind_t k, input logic [31:0] h);
    result_t     res;
    logic [9:0]  slot;
    bit          got;
    res.handle = 32'h0;
    res.status = gha_pkg::STATUS_INVALID;
    got = 1'b0;
    slot = '0;
    case (k)
      gha_pkg::KIND_ALLOCATE: begin
        if (free_depth > 0) begin
          free_depth--;
          slot = free_slots[free_depth];
          got = 1'b1;
        end else if (fresh_taken < SLOTS) begin
          slot = fresh_taken[9:0];
          fresh_taken++;
          got = 1'b1;
        end
        if (got) begin
          slot_gen[slot] = (slot_gen[slot] == gha_pkg::GEN_MAX) ? gha_pkg::GEN_ONE :
                           slot_gen[slot] + 1'b1;
          slot_busy[slot] = 1'b1;
          res.handle = {slot_gen[slot], 10'b0, slot};
          res.status = gha_pkg::STATUS_OK;
          live_handles.insert(live_handles.size(), res.handle);
        end else begin
          res.status = gha_pkg::STATUS_FULL;
          full_answers++;
        end
      end
      gha_pkg::KIND_RELEASE: begin
        if (handle_live(h)) begin
          slot_busy[h[9:0]] = 1'b0;
          free_slots[free_depth] = h[9:0];
          free_depth++;
          res.status = gha_pkg::STATUS_OK;
          foreach (live_handles[i]) begin
            if (live_handles[i] == h) begin
              live_handles.delete(i);
              break;
            end
          end
          retired_handles.insert(retired_handles.size(), h);
          if (retired_handles.size() > 64) void'(retired_handles.pop_front());
        end
      end
      gha_pkg::KIND_VALIDATE: begin
        if (handle_live(h)) res.status = gha_pkg::STATUS_OK;
      end
      default: ;
    endcase
    awaited_results.insert(awaited_results.size(), res);
  endfunction

  // Sender: offers the oldest pending request and keeps it steady while stalled.
  always @(posedge clk) begin : drive_requests
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_transaction(gha_pkg::kind_t'(in_kind), in_handle_in);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
          req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_kind <= req.kind;
          in_handle_in <= req.handle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result handle %h status %0d",
                                  out_handle_out, out_status));
      end else begin
        want = awaited_results.pop_front();
        if (out_handle_out !== want.handle)
          report_mismatch($sformatf("handle_out %h, expected %h", out_handle_out, want.handle));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
      end
    end
    out_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < 32);
  end

  // One long hold-off on the result side so the block backs up into its input.
  always @(posedge clk) begin
    if (!hold_done && results_seen == 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic queue_request(input gha_pkg::kind_t k, input logic [31:0] h);
    request_t req;
    while (pending_requests.size() >= 2) @(negedge clk);
    req.kind = k;
    req.handle = h;
    pending_requests.insert(pending_requests.size(), req);
    n_queued++;
  endtask

  function automatic logic [31:0] pick_live();
    if (live_handles.size() == 0) return $urandom;
    return live_handles[$urandom_range(live_handles.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_stale();
    if (retired_handles.size() == 0) return $urandom;
    return retired_handles[$urandom_range(retired_handles.size() - 1)];
  endfunction

  // Mostly well-formed traffic built from handles that are live right now.
  task automatic plan_mixed(input int unsigned alloc_pct);
    int unsigned    r;
    gha_pkg::kind_t check_kind;
    r = $urandom_range(99);
    check_kind = $urandom_range(1) ? gha_pkg::KIND_RELEASE : gha_pkg::KIND_VALIDATE;
    if (r < alloc_pct) begin
      queue_request(gha_pkg::KIND_ALLOCATE, $urandom);
    end else begin
      r = $urandom_range(99);
      if (r < 40)
        queue_request(gha_pkg::KIND_RELEASE, pick_live());
      else if (r < 65)
        queue_request(gha_pkg::KIND_VALIDATE, pick_live());
      else if (r < 75)
        queue_request(check_kind, pick_stale());
      else if (r < 85)
        queue_request(check_kind, pick_live() ^ (32'h1 << $urandom_range(31)));
      else
        queue_request(gha_pkg::kind_t'($urandom_range(3)), $urandom);
    end
  endtask

  initial begin : stimulus
    int unsigned guard;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: zero handle, slot beyond the fresh count, out-of-range slot,
    // wrong generation, unused kind, double release and LIFO reuse order.
    queue_request(gha_pkg::KIND_VALIDATE, 32'h0000_0000);
    queue_request(gha_pkg::KIND_RELEASE,  32'h0000_0000);
    queue_request(gha_pkg::KIND_ALLOCATE, 32'h0000_0000);
    queue_request(gha_pkg::KIND_ALLOCATE, 32'hFFFF_FFFF);
    queue_request(gha_pkg::KIND_VALIDATE, 32'h0010_0000);
    queue_request(gha_pkg::KIND_VALIDATE, 32'h0010_0005);
    queue_request(gha_pkg::KIND_VALIDATE, 32'hFFFF_FFFF);
    queue_request(gha_pkg::KIND_VALIDATE, 32'h001F_FFFF);
    queue_request(gha_pkg::KIND_VALIDATE, 32'h0020_0000);
    queue_request(gha_pkg::KIND_UNUSED,   32'h0010_0000);
    queue_request(gha_pkg::KIND_RELEASE,  32'h0010_0000);
    queue_request(gha_pkg::KIND_RELEASE,  32'h0010_0000);
    queue_request(gha_pkg::KIND_VALIDATE, 32'h0010_0000);
    queue_request(gha_pkg::KIND_ALLOCATE, 32'h0000_0000);
    queue_request(gha_pkg::KIND_VALIDATE, 32'h0020_0000);
    queue_request(gha_pkg::KIND_ALLOCATE, 32'hFFFF_FFFF);
    queue_request(gha_pkg::KIND_RELEASE,  32'h0010_0001);
    queue_request(gha_pkg::KIND_RELEASE,  32'h0010_0002);
    queue_request(gha_pkg::KIND_ALLOCATE, 32'h0000_0000);
    queue_request(gha_pkg::KIND_ALLOCATE, 32'h0000_0000);
    queue_request(gha_pkg::KIND_VALIDATE, 32'h0020_0001);
    queue_request(gha_pkg::KIND_UNUSED,   32'hFFFF_FFFF);
    queue_request(gha_pkg::KIND_RELEASE,  32'h0020_0000);
    queue_request(gha_pkg::KIND_VALIDATE, 32'h0000_0001);

    repeat (200) plan_mixed(45);

    // Fill the table until every slot has been taken fresh and allocation reports full.
    guard = 0;
    while ((fresh_taken < SLOTS || full_answers < 16) && guard < 4000) begin
      plan_mixed(95);
      guard++;
    end

    calm = 1'b1;
    repeat (100) plan_mixed(40);
    calm = 1'b0;
    repeat (100) plan_mixed(40);
    repeat (20) plan_mixed(50);

    while (n_accepted != n_queued) @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("Run timed out with %0d results outstanding", awaited_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
